// ----- sv/ptw_pkg.sv -----
// ----------------------------------------------------------------------------
// ptw_pkg
// shared constants, register codes, event codes and configuration type for
// the predictive thermal warning block
// ----------------------------------------------------------------------------
package ptw_pkg;

   // history ring
   localparam int HISTORY_DEPTH = 8;
   localparam int POS_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   // field widths
   localparam int READING_W = 16;
   localparam int HALF_W    = 11;
   localparam int BATT_W    = 8;
   localparam int KIND_W    = 2;
   localparam int MAG_W     = 15;
   localparam int CELSIUS_W = 11;
   localparam int ACC_W     = 8;

   // datapath widths
   localparam int DIFF_W   = HALF_W + 1;
   localparam int SCALED_W = DIFF_W + 5;
   localparam int OFFSET_W = 18;
   localparam int PROD_W   = 25;

   localparam int KELVIN_OFFSET = 275;
   localparam int SHRINK        = 3;
   localparam int COLD_MARGIN   = 4;
   localparam int HOT_SHIFT     = 7;

   localparam logic [MAG_W-1:0] MAG_MAX = '1;

   // event codes
   localparam logic [KIND_W-1:0] EVT_NONE = 2'd0;
   localparam logic [KIND_W-1:0] EVT_HOT  = 2'd1;
   localparam logic [KIND_W-1:0] EVT_COLD = 2'd2;
   localparam logic [KIND_W-1:0] EVT_OKAY = 2'd3;

   // register map
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_CEILING     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_CALIBRATION = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_LOW_VOLTAGE = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_LOOKAHEAD   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SPACING     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_RESPONSE    = 3'd5;

   typedef struct packed {
      logic [6:0]        ceiling_celsius;
      logic signed [7:0] calibration_offset;
      logic [7:0]        low_voltage_level;
      logic [3:0]        lookahead_gain;
      logic [6:0]        warning_spacing;
      logic [7:0]        response_gain;
   } cfg_type;

   localparam logic [6:0] RST_CEILING     = 7'd45;
   localparam logic [7:0] RST_CALIBRATION = 8'd0;
   localparam logic [7:0] RST_LOW_VOLTAGE = 8'd145;
   localparam logic [3:0] RST_LOOKAHEAD   = 4'd4;
   localparam logic [6:0] RST_SPACING     = 7'd24;
   localparam logic [7:0] RST_RESPONSE    = 8'd64;

endpackage

// ----- sv/ptw_req_if.sv -----
// ----------------------------------------------------------------------------
// ptw_req_if
// reading channel: one temperature word per handshake
// ----------------------------------------------------------------------------
interface ptw_req_if;
   logic                                valid;
   logic                                ready;
   logic [ptw_pkg::READING_W-1:0]       reading_k64;
   logic                                wipe_history;
   logic [ptw_pkg::BATT_W-1:0]          battery_level;

   modport source (output valid, output reading_k64, output wipe_history,
                   output battery_level, input ready);
   modport sink   (input valid, input reading_k64, input wipe_history,
                   input battery_level, output ready);
endinterface

// ----- sv/ptw_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ptw_rsp_if
// event channel: one warning word per handshake
// ----------------------------------------------------------------------------
interface ptw_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ptw_pkg::KIND_W-1:0]          event_kind;
   logic [ptw_pkg::MAG_W-1:0]           event_magnitude;
   logic signed [ptw_pkg::CELSIUS_W-1:0] temp_celsius;

   modport source (output valid, output event_kind, output event_magnitude,
                   output temp_celsius, input ready);
   modport sink   (input valid, input event_kind, input event_magnitude,
                   input temp_celsius, output ready);
endinterface

// ----- sv/ptw_ram.sv -----
// ----------------------------------------------------------------------------
// ptw_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ptw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/ptw_csr.sv -----
// ----------------------------------------------------------------------------
// ptw_csr
// configuration registers behind an apb-style port
// ----------------------------------------------------------------------------
module ptw_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ptw_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ptw_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ptw_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output ptw_pkg::cfg_type                  cfg
);

   ptw_pkg::cfg_type                  cfg_ff;
   logic [ptw_pkg::REG_IDX_W-1:0]     reg_idx;
   logic                              wr_strobe;

   assign reg_idx   = paddr[ptw_pkg::CSR_ADDR_W-1:2];
   assign wr_strobe = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ceiling_celsius    <= ptw_pkg::RST_CEILING;
         cfg_ff.calibration_offset <= ptw_pkg::RST_CALIBRATION;
         cfg_ff.low_voltage_level  <= ptw_pkg::RST_LOW_VOLTAGE;
         cfg_ff.lookahead_gain     <= ptw_pkg::RST_LOOKAHEAD;
         cfg_ff.warning_spacing    <= ptw_pkg::RST_SPACING;
         cfg_ff.response_gain      <= ptw_pkg::RST_RESPONSE;
      end else if (wr_strobe) begin
         unique case (reg_idx)
            ptw_pkg::REG_CEILING:     cfg_ff.ceiling_celsius    <= pwdata[6:0];
            ptw_pkg::REG_CALIBRATION: cfg_ff.calibration_offset <= pwdata[7:0];
            ptw_pkg::REG_LOW_VOLTAGE: cfg_ff.low_voltage_level  <= pwdata[7:0];
            ptw_pkg::REG_LOOKAHEAD:   cfg_ff.lookahead_gain     <= pwdata[3:0];
            ptw_pkg::REG_SPACING:     cfg_ff.warning_spacing    <= pwdata[6:0];
            ptw_pkg::REG_RESPONSE:    cfg_ff.response_gain      <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         ptw_pkg::REG_CEILING:     prdata[6:0] = cfg_ff.ceiling_celsius;
         ptw_pkg::REG_CALIBRATION: prdata[7:0] = cfg_ff.calibration_offset;
         ptw_pkg::REG_LOW_VOLTAGE: prdata[7:0] = cfg_ff.low_voltage_level;
         ptw_pkg::REG_LOOKAHEAD:   prdata[3:0] = cfg_ff.lookahead_gain;
         ptw_pkg::REG_SPACING:     prdata[6:0] = cfg_ff.warning_spacing;
         ptw_pkg::REG_RESPONSE:    prdata[7:0] = cfg_ff.response_gain;
         default:                  prdata      = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/ptw_core.sv -----
// ----------------------------------------------------------------------------
// ptw_core
// sequencer and datapath: ring read-modify-write, prediction, warning pacing
// ----------------------------------------------------------------------------
module ptw_core (
   input  logic             clock,
   input  logic             reset,
   input  ptw_pkg::cfg_type cfg,
   ptw_req_if.sink          req,
   ptw_rsp_if.source        rsp
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_WIPE   = 3'd1;
   localparam logic [2:0] ST_DIFF   = 3'd2;
   localparam logic [2:0] ST_SCALE  = 3'd3;
   localparam logic [2:0] ST_OFFSET = 3'd4;
   localparam logic [2:0] ST_HOT    = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   localparam logic [ptw_pkg::POS_W-1:0] POS_LAST = ptw_pkg::POS_W'(ptw_pkg::HISTORY_DEPTH - 1);

   logic [2:0]                              state_ff;
   logic [ptw_pkg::POS_W-1:0]               pos_ff;
   logic [ptw_pkg::POS_W-1:0]               sweep_ff;
   logic signed [ptw_pkg::ACC_W-1:0]        acc_ff;

   logic [ptw_pkg::READING_W-1:0]           reading_ff;
   logic                                    wipe_ff;
   logic [ptw_pkg::BATT_W-1:0]              battery_ff;
   logic signed [ptw_pkg::DIFF_W-1:0]       diff_ff;
   logic signed [ptw_pkg::SCALED_W-1:0]     scaled_ff;
   logic signed [ptw_pkg::OFFSET_W-1:0]     offset_ff;
   logic [ptw_pkg::PROD_W-1:0]              prod_ff;
   logic                                    t_neg_ff;

   logic                                    rsp_valid_ff;
   logic [ptw_pkg::KIND_W-1:0]              kind_ff;
   logic [ptw_pkg::MAG_W-1:0]               mag_ff;
   logic signed [ptw_pkg::CELSIUS_W-1:0]    celsius_ff;

   logic                                    accept;
   logic                                    load_out;
   logic [ptw_pkg::HALF_W-1:0]              half_k;
   logic                                    ram_wr_en;
   logic [ptw_pkg::POS_W-1:0]               ram_wr_addr;
   logic [ptw_pkg::HALF_W-1:0]              ram_rd_data;

   logic signed [ptw_pkg::DIFF_W-1:0]       diff_in;
   logic signed [ptw_pkg::SCALED_W-1:0]     scaled_in;
   logic signed [ptw_pkg::OFFSET_W-1:0]     predicted;
   logic signed [ptw_pkg::HALF_W-1:0]       ceil_k;
   logic signed [ptw_pkg::OFFSET_W-1:0]     raw_offset;
   logic signed [ptw_pkg::OFFSET_W-1:0]     offset_in;
   logic signed [ptw_pkg::OFFSET_W:0]       hot_t;
   logic [ptw_pkg::PROD_W-1:0]              prod_in;

   logic signed [ptw_pkg::OFFSET_W-1:0]     below;
   logic [ptw_pkg::OFFSET_W-1:0]            neg_below;
   logic [ptw_pkg::PROD_W-ptw_pkg::HOT_SHIFT-1:0] h_raw;
   logic [ptw_pkg::MAG_W-1:0]               h_mag;
   logic                                    hot_cond;
   logic                                    cold_cond;
   logic                                    acc_pos;
   logic [ptw_pkg::ACC_W-1:0]               spacing8;
   logic [ptw_pkg::KIND_W-1:0]              kind_in;
   logic [ptw_pkg::MAG_W-1:0]               mag_in;
   logic [ptw_pkg::ACC_W-1:0]               acc_in;
   logic signed [ptw_pkg::CELSIUS_W-1:0]    celsius_in;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign load_out  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);
   assign half_k    = reading_ff[ptw_pkg::READING_W-1:5];

   // ring store: read at accept, written during the sweep and at diff
   assign ram_wr_en   = (state_ff == ST_WIPE) || (state_ff == ST_DIFF);
   assign ram_wr_addr = (state_ff == ST_WIPE) ? sweep_ff : pos_ff;

   ptw_ram #(
      .WIDTH (ptw_pkg::HALF_W),
      .DEPTH (ptw_pkg::HISTORY_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (half_k),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   // datapath per stage
   always_comb begin
      diff_in   = wipe_ff ? '0
                : $signed({1'b0, half_k}) - $signed({1'b0, ram_rd_data});
      scaled_in = diff_ff * $signed({1'b0, cfg.lookahead_gain});
      predicted = ptw_pkg::OFFSET_W'(scaled_ff)
                + $signed({{(ptw_pkg::OFFSET_W-ptw_pkg::HALF_W){1'b0}}, half_k});
      ceil_k    = $signed({4'd0, cfg.ceiling_celsius})
                + $signed(ptw_pkg::HALF_W'(ptw_pkg::KELVIN_OFFSET))
                - $signed({{(ptw_pkg::HALF_W-8){cfg.calibration_offset[7]}},
                           cfg.calibration_offset});
      raw_offset = predicted - $signed({{(ptw_pkg::OFFSET_W-ptw_pkg::HALF_W-1){ceil_k[10]}},
                                        ceil_k, 1'b0});
      if (raw_offset > $signed(ptw_pkg::OFFSET_W'(ptw_pkg::SHRINK))) begin
         offset_in = raw_offset - $signed(ptw_pkg::OFFSET_W'(ptw_pkg::SHRINK));
      end else if (raw_offset < -$signed(ptw_pkg::OFFSET_W'(ptw_pkg::SHRINK))) begin
         offset_in = raw_offset + $signed(ptw_pkg::OFFSET_W'(ptw_pkg::SHRINK));
      end else begin
         offset_in = '0;
      end
      hot_t   = $signed({offset_ff, 1'b0}) - $signed((ptw_pkg::OFFSET_W+1)'(3));
      prod_in = ptw_pkg::PROD_W'(hot_t[16:0]) * ptw_pkg::PROD_W'(cfg.response_gain);
   end

   // decision at the end of an item
   always_comb begin
      below     = offset_ff + $signed(ptw_pkg::OFFSET_W'(ptw_pkg::COLD_MARGIN));
      neg_below = ptw_pkg::OFFSET_W'(-below);
      h_raw     = prod_ff[ptw_pkg::PROD_W-1:ptw_pkg::HOT_SHIFT];
      if (t_neg_ff || (h_raw == '0)) begin
         h_mag = ptw_pkg::MAG_W'(1);
      end else if (h_raw > (ptw_pkg::PROD_W-ptw_pkg::HOT_SHIFT)'(ptw_pkg::MAG_MAX)) begin
         h_mag = ptw_pkg::MAG_MAX;
      end else begin
         h_mag = h_raw[ptw_pkg::MAG_W-1:0];
      end
      hot_cond  = (offset_ff > 0) && !diff_ff[ptw_pkg::DIFF_W-1];
      cold_cond = below[ptw_pkg::OFFSET_W-1] && diff_ff[ptw_pkg::DIFF_W-1];
      acc_pos   = !acc_ff[ptw_pkg::ACC_W-1] && (acc_ff != '0);
      spacing8  = {1'b0, cfg.warning_spacing};
      kind_in   = ptw_pkg::EVT_NONE;
      mag_in    = '0;
      acc_in    = acc_ff;
      if (hot_cond) begin
         if (acc_pos) begin
            acc_in = acc_ff - offset_ff[ptw_pkg::ACC_W-1:0];
         end else begin
            acc_in  = spacing8 - h_mag[ptw_pkg::ACC_W-1:0];
            kind_in = ptw_pkg::EVT_HOT;
            mag_in  = h_mag;
         end
      end else if (cold_cond) begin
         if (acc_ff[ptw_pkg::ACC_W-1]) begin
            acc_in = acc_ff - below[ptw_pkg::ACC_W-1:0];
         end else begin
            acc_in = -spacing8 - below[ptw_pkg::ACC_W-1:0];
            if ({1'b0, battery_ff} > ({1'b0, cfg.low_voltage_level} + 9'd1)) begin
               kind_in = ptw_pkg::EVT_COLD;
               mag_in  = neg_below[ptw_pkg::MAG_W:1];
            end
         end
      end else if (battery_ff > cfg.low_voltage_level) begin
         kind_in = ptw_pkg::EVT_OKAY;
      end
      celsius_in = $signed({1'b0, reading_ff[ptw_pkg::READING_W-1:6]})
                 + $signed({{(ptw_pkg::CELSIUS_W-8){cfg.calibration_offset[7]}},
                            cfg.calibration_offset})
                 - $signed(ptw_pkg::CELSIUS_W'(ptw_pkg::KELVIN_OFFSET));
   end

   // sequencer and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         sweep_ff     <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
            acc_ff       <= acc_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               sweep_ff <= '0;
               if (accept) begin
                  state_ff <= req.wipe_history ? ST_WIPE : ST_DIFF;
               end
            end
            ST_WIPE: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == POS_LAST) begin
                  state_ff <= ST_DIFF;
               end
            end
            ST_DIFF: begin
               pos_ff   <= (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
               state_ff <= ST_SCALE;
            end
            ST_SCALE:  state_ff <= ST_OFFSET;
            ST_OFFSET: state_ff <= ST_HOT;
            ST_HOT:    state_ff <= ST_DONE;
            ST_DONE: begin
               if (load_out) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         reading_ff <= req.reading_k64;
         wipe_ff    <= req.wipe_history;
         battery_ff <= req.battery_level;
      end
      if (state_ff == ST_DIFF) begin
         diff_ff <= diff_in;
      end
      if (state_ff == ST_SCALE) begin
         scaled_ff <= scaled_in;
      end
      if (state_ff == ST_OFFSET) begin
         offset_ff <= offset_in;
      end
      if (state_ff == ST_HOT) begin
         prod_ff  <= prod_in;
         t_neg_ff <= hot_t[ptw_pkg::OFFSET_W];
      end
      if (load_out) begin
         kind_ff    <= kind_in;
         mag_ff     <= mag_in;
         celsius_ff <= celsius_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.event_kind      = kind_ff;
   assign rsp.event_magnitude = mag_ff;
   assign rsp.temp_celsius    = celsius_ff;

endmodule

// ----- sv/predictive_thermal_warning_top.sv -----
// ----------------------------------------------------------------------------
// predictive_thermal_warning_top
// temperature trend predictor with paced too-hot and too-cold warnings
// ----------------------------------------------------------------------------
//
//   port group   direction  carries
//   req_chan     in         reading_k64, wipe_history, battery_level
//   rsp_chan     out        event_kind, event_magnitude, temp_celsius
//   csr_*        in/out     apb-style register access, six registers
//
// one word in gives one word out, through the diff, scale, offset and hot steps
// next word is taken only once the previous result is in the output register
//   (one ring read, one ring write and two registered multiplies in sequence)
// a word with wipe_history set first fills all HISTORY_DEPTH ring entries,
//   one entry per cycle through the single write port
// a finished word waits in the output register; a new word may be taken
//   meanwhile, but the next result holds until the first is taken
// synchronous active-high reset clears control, ring position and pacing
//   accumulator; ring contents are undefined until the first wipe
//
module predictive_thermal_warning_top (
   input  logic                              clock,
   input  logic                              reset,
   ptw_req_if.sink                           req_chan,
   ptw_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ptw_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ptw_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ptw_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   // live configuration shared with the datapath
   ptw_pkg::cfg_type cfg;

   // register file
   ptw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // sequencer, ring memory and warning datapath
   ptw_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

endmodule

// ----- sv/ptw_checker.sv -----
// ----------------------------------------------------------------------------
// ptw_checker
// port-level checks on the predictive thermal warning block
// ----------------------------------------------------------------------------
module ptw_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [ptw_pkg::KIND_W-1:0]         event_kind,
   input logic [ptw_pkg::MAG_W-1:0]          event_magnitude,
   input logic                               csr_pready
);

   // no stale word survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_kind)
                                 && $stable(event_magnitude))
      else $error("stalled result word changed");

   // okay and none carry no magnitude
   a_quiet_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (event_kind == ptw_pkg::EVT_NONE || event_kind == ptw_pkg::EVT_OKAY)
      |-> event_magnitude == '0)
      else $error("magnitude on a quiet event");

   // a hot warning always has some size
   a_hot_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (event_kind == ptw_pkg::EVT_HOT) |-> event_magnitude != '0)
      else $error("hot event with zero magnitude");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port stalled");

endmodule

bind predictive_thermal_warning_top ptw_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .event_kind      (rsp_chan.event_kind),
   .event_magnitude (rsp_chan.event_magnitude),
   .csr_pready      (csr_pready)
);
